FILE: sv/nmea_rmc_gga_position_parser_defines.svh
// Assertion macros for the checker file of the position parser.
`ifndef NMEA_RMC_GGA_POSITION_PARSER_DEFINES_SVH
`define NMEA_RMC_GGA_POSITION_PARSER_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define NRGPP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define NRGPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/nrgpp_pkg.sv
`timescale 1ns / 1ps

package nrgpp_pkg;

   typedef logic [7:0]         byte_type;
   typedef logic signed [30:0] lat_type;
   typedef logic signed [34:0] lon_type;
   typedef logic [7:0]         sat_type;

   localparam byte_type CHAR_LF     = 8'h0A;
   localparam byte_type CHAR_CR     = 8'h0D;
   localparam byte_type CHAR_SPACE  = 8'h20;
   localparam byte_type CHAR_TAB    = 8'h09;
   localparam byte_type CHAR_VT     = 8'h0B;
   localparam byte_type CHAR_FF     = 8'h0C;
   localparam byte_type CHAR_DOLLAR = 8'h24;
   localparam byte_type CHAR_STAR   = 8'h2A;
   localparam byte_type CHAR_COMMA  = 8'h2C;
   localparam byte_type CHAR_DOT    = 8'h2E;
   localparam byte_type CHAR_PLUS   = 8'h2B;
   localparam byte_type CHAR_MINUS  = 8'h2D;
   localparam byte_type CHAR_ZERO   = 8'h30;
   localparam byte_type CHAR_NINE   = 8'h39;
   localparam byte_type CHAR_A      = 8'h41;
   localparam byte_type CHAR_C      = 8'h43;
   localparam byte_type CHAR_G      = 8'h47;
   localparam byte_type CHAR_M      = 8'h4D;
   localparam byte_type CHAR_R      = 8'h52;
   localparam byte_type CHAR_S      = 8'h53;
   localparam byte_type CHAR_W      = 8'h57;

   localparam int FL_STARTED  = 0;
   localparam int FL_CR       = 1;
   localparam int FL_STAR     = 2;
   localparam int FL_DOLLAR   = 3;
   localparam int FL_TALKER_G = 4;
   localparam int FL_STATUS_A = 5;
   localparam int FL_LAT_LEN  = 6;
   localparam int FL_LON_LEN  = 7;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_RMC  = 2'd1;
   localparam logic [1:0] KIND_GGA  = 2'd2;

   localparam logic [1:0] PH_LEAD = 2'd0;
   localparam logic [1:0] PH_INT  = 2'd1;
   localparam logic [1:0] PH_FRAC = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic [4:0] FIELD_STATUS = 5'd2;
   localparam logic [4:0] FIELD_LAT    = 5'd3;
   localparam logic [4:0] FIELD_NS     = 5'd4;
   localparam logic [4:0] FIELD_LON    = 5'd5;
   localparam logic [4:0] FIELD_EW     = 5'd6;
   localparam logic [4:0] FIELD_SATS   = 5'd7;
   localparam logic [4:0] FIELD_MAX    = 5'd31;

   localparam logic [23:0] MAX24 = 24'hFFFFFF;
   localparam logic [23:0] TEN7  = 24'd10000000;

   localparam int MAG_W = 36;
   localparam logic [MAG_W-1:0] LAT_CAP = 36'd1000000000;
   localparam logic [MAG_W-1:0] LON_CAP = 36'd10000000000;

   // Minutes are divided by 60 as a multiply by ceil(2^44 / 15) after a shift by 2.
   localparam int X_W     = 39;
   localparam int RECIP_K = 44;
   localparam logic [40:0] RECIP = 41'((64'd1 << RECIP_K) / 64'd15 + 64'd1);

   function automatic logic is_ws(byte_type c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
   endfunction

   function automatic logic is_digit(byte_type c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic longint unsigned pow10(int n);
      longint unsigned p;
      p = 1;
      for (int j = 0; j < n; j++) begin
         p = p * 10;
      end
      return p;
   endfunction

endpackage

FILE: sv/nrgpp_if.sv
`timescale 1ns / 1ps

interface nrgpp_req_if;
   import nrgpp_pkg::*;
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrgpp_rsp_if;
   import nrgpp_pkg::*;
   logic    valid;
   logic    ready;
   logic    line_accepted;
   logic    position_valid;
   lat_type latitude;
   lon_type longitude;
   logic    satellites_valid;
   sat_type satellites;
   modport source (output valid, output line_accepted, output position_valid,
                   output latitude, output longitude, output satellites_valid,
                   output satellites, input ready);
   modport sink (input valid, input line_accepted, input position_valid,
                 input latitude, input longitude, input satellites_valid,
                 input satellites, output ready);
endinterface

interface nrgpp_csr_if;
   logic valid;
   logic ready;
   logic require_g_talker;
   modport source (output valid, output require_g_talker, input ready);
   modport sink (input valid, input require_g_talker, output ready);
endinterface

FILE: sv/nmea_rmc_gga_position_parser.sv
`timescale 1ns / 1ps

// NMEA RMC / GGA position parser.
// The req channel takes one received character per word; a line ends with LF.
// Every other character updates the line parser in the cycle it is accepted,
// so one word per cycle is taken as long as the result pipeline has room.
// Each LF produces exactly one word on the rsp channel: line_accepted,
// position_valid with latitude and longitude in 1e-7 degree, and
// satellites_valid with the GGA satellite count.
// The result of an LF reaches rsp through the pipeline that pads the
// minutes, divides them by 60 with a split reciprocal multiply, adds the
// degrees and applies the sign.
// The csr channel writes require_g_talker and is always ready; write it only
// while no line result is outstanding.
// Reset clears the line parser, the valid flags of the pipeline and the register.
// When rsp is stalled, results collect in the empty pipeline stages, and req
// drops ready only when every stage holds a result.
module nmea_rmc_gga_position_parser #(
   parameter int LINE_LIMIT             = 256,
   parameter int MINUTE_FRACTION_DIGITS = 5
) (
   input  logic        clock,
   input  logic        reset,
   nrgpp_req_if.sink   req,
   nrgpp_rsp_if.source rsp,
   nrgpp_csr_if.sink   csr
);
   import nrgpp_pkg::*;

   localparam int CW = $clog2(LINE_LIMIT + 1);
   localparam int NS = 6;
   localparam logic [16:0] POW_SCALE = 17'(pow10(7 - MINUTE_FRACTION_DIGITS));

   typedef struct packed {
      logic [9:0]  deg;
      logic [23:0] mins;
      logic [2:0]  frac;
      logic [1:0]  dphase;
      logic [1:0]  mphase;
   } coord_type;

   typedef struct packed {
      logic [9:0]       deg;
      logic [23:0]      mins;
      logic [2:0]       frac;
      logic             neg;
      logic [X_W-1:0]   x;
      logic [33:0]      dm;
      logic [41:0]      pp_hh;
      logic [41:0]      pp_hl;
      logic [41:0]      pp_lh;
      logic [41:0]      pp_ll;
      logic [MAG_W-1:0] mag;
   } cpipe_type;

   typedef struct packed {
      logic      accepted;
      logic      rmc;
      logic      gga;
      sat_type   sat;
      cpipe_type lat;
      cpipe_type lon;
   } stage_type;

   function automatic coord_type coord_char(coord_type s, byte_type c, logic [CW-1:0] pos,
                                            logic [1:0] dd);
      coord_type   r;
      logic [27:0] v;
      r = s;
      v = 28'(s.mins) * 28'd10 + 28'(c[3:0]);
      if (pos < CW'(dd)) begin
         if (!(s.dphase == PH_LEAD && is_ws(c))) begin
            if ((s.dphase == PH_LEAD || s.dphase == PH_INT) && is_digit(c)) begin
               r.deg = 10'(s.deg * 10'd10 + 10'(c[3:0]));
               r.dphase = PH_INT;
            end else begin
               r.dphase = PH_DONE;
            end
         end
      end else if (!(s.mphase == PH_LEAD && is_ws(c))) begin
         if (s.mphase == PH_LEAD || s.mphase == PH_INT) begin
            if (is_digit(c)) begin
               r.mins = (v > 28'(MAX24)) ? MAX24 : v[23:0];
               r.mphase = PH_INT;
            end else if (c == CHAR_DOT) begin
               r.mphase = PH_FRAC;
            end else begin
               r.mphase = PH_DONE;
            end
         end else if (s.mphase == PH_FRAC) begin
            if (is_digit(c)) begin
               if (s.frac < 3'(MINUTE_FRACTION_DIGITS)) begin
                  r.mins = (v > 28'(MAX24)) ? MAX24 : v[23:0];
                  r.frac = s.frac + 3'd1;
               end
            end else begin
               r.mphase = PH_DONE;
            end
         end
      end
      return r;
   endfunction

   function automatic cpipe_type pad_fn(cpipe_type c);
      cpipe_type   r;
      logic [27:0] v;
      r = c;
      for (int j = 0; j < MINUTE_FRACTION_DIGITS; j++) begin
         if (3'(j) >= c.frac) begin
            v = 28'(r.mins) * 28'd10;
            r.mins = (v > 28'(MAX24)) ? MAX24 : v[23:0];
         end
      end
      return r;
   endfunction

   function automatic cpipe_type mult_fn(cpipe_type c);
      cpipe_type   r;
      logic [40:0] a;
      r = c;
      a = 41'(c.mins) * 41'(POW_SCALE) + 41'd30;
      r.x = X_W'(a >> 2);
      r.dm = 34'(c.deg) * 34'(TEN7);
      return r;
   endfunction

   function automatic cpipe_type pp_fn(cpipe_type c);
      cpipe_type r;
      r = c;
      r.pp_hh = 42'(c.x[X_W-1:20]) * 42'(RECIP[40:20]);
      r.pp_hl = 42'(c.x[X_W-1:20]) * 42'(RECIP[19:0]);
      r.pp_lh = 42'(c.x[19:0]) * 42'(RECIP[40:20]);
      r.pp_ll = 42'(c.x[19:0]) * 42'(RECIP[19:0]);
      return r;
   endfunction

   function automatic cpipe_type sum_fn(cpipe_type c);
      cpipe_type   r;
      logic [81:0] p;
      r = c;
      p = (82'(c.pp_hh) << 40) + (82'(c.pp_hl) << 20) + (82'(c.pp_lh) << 20) + 82'(c.pp_ll);
      r.mag = MAG_W'(p >> RECIP_K);
      return r;
   endfunction

   function automatic cpipe_type mag_fn(cpipe_type c, logic [MAG_W-1:0] cap);
      cpipe_type    r;
      logic [MAG_W:0] s;
      r = c;
      s = (MAG_W + 1)'(c.dm) + (MAG_W + 1)'(c.mag);
      r.mag = (s > (MAG_W + 1)'(cap)) ? cap : s[MAG_W-1:0];
      return r;
   endfunction

   logic           cfg_g_ff;
   logic [CW-1:0]  char_count_ff, char_count_in;
   logic [4:0]     field_index_ff, field_index_in;
   logic [CW-1:0]  fcc_ff, fcc_in;
   logic [7:0]     flags_ff, flags_in;
   logic [1:0]     kind_ff, kind_in;
   logic [6:0]     lat_deg_ff, lat_deg_in;
   logic [23:0]    lat_min_ff, lat_min_in;
   logic [9:0]     lon_deg_ff, lon_deg_in;
   logic [23:0]    lon_min_ff, lon_min_in;
   logic [1:0]     hem_ff, hem_in;
   sat_type        sat_acc_ff, sat_acc_in;
   logic [2:0]     trim_ff, trim_in;
   logic [CW-1:0]  blank_run_ff, blank_run_in;
   logic [1:0]     dphase_ff, dphase_in;
   logic [1:0]     mphase_ff, mphase_in;
   logic [1:0]     sphase_ff, sphase_in;
   logic [2:0]     lat_frac_ff, lat_frac_in;
   logic [2:0]     lon_frac_ff, lon_frac_in;
   logic           sneg_ff, sneg_in;
   logic           sseen_ff, sseen_in;

   logic           byte_fire;
   logic [NS+1:1]  rdy;
   logic [NS:1]    v_ff;
   stage_type      st_ff [1:NS];
   stage_type      st_in [1:NS];

   logic           rsp_valid_ff;
   logic           accepted_ff, position_valid_ff, satellites_valid_ff;
   lat_type        latitude_ff, latitude_in;
   lon_type        longitude_ff, longitude_in;
   sat_type        satellites_ff;

   assign byte_fire = req.valid && req.ready;
   assign req.ready = rdy[1];
   assign csr.ready = 1'b1;

   always_comb begin
      rdy[NS+1] = !rsp_valid_ff || rsp.ready;
      for (int k = NS; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      byte_type       c;
      logic [CW:0]    tsum;
      logic [CW:0]    fsum;
      logic [CW:0]    iend;
      logic [CW-1:0]  i;
      logic [1:0]     dd;
      logic [11:0]    sat_sum;
      coord_type      co;
      char_count_in  = char_count_ff;
      field_index_in = field_index_ff;
      fcc_in         = fcc_ff;
      flags_in       = flags_ff;
      kind_in        = kind_ff;
      lat_deg_in     = lat_deg_ff;
      lat_min_in     = lat_min_ff;
      lon_deg_in     = lon_deg_ff;
      lon_min_in     = lon_min_ff;
      hem_in         = hem_ff;
      sat_acc_in     = sat_acc_ff;
      trim_in        = trim_ff;
      blank_run_in   = blank_run_ff;
      dphase_in      = dphase_ff;
      mphase_in      = mphase_ff;
      sphase_in      = sphase_ff;
      lat_frac_in    = lat_frac_ff;
      lon_frac_in    = lon_frac_ff;
      sneg_in        = sneg_ff;
      sseen_in       = sseen_ff;
      c       = req.rx_byte;
      tsum    = '0;
      fsum    = '0;
      iend    = '0;
      i       = '0;
      dd      = 2'd2;
      sat_sum = '0;
      co      = '0;
      if (byte_fire) begin
         if (c == CHAR_LF) begin
            char_count_in  = '0;
            field_index_in = '0;
            fcc_in         = '0;
            flags_in       = '0;
            kind_in        = KIND_NONE;
            lat_deg_in     = '0;
            lat_min_in     = '0;
            lon_deg_in     = '0;
            lon_min_in     = '0;
            hem_in         = '0;
            sat_acc_in     = '0;
            trim_in        = '0;
            blank_run_in   = '0;
            dphase_in      = PH_LEAD;
            mphase_in      = PH_LEAD;
            sphase_in      = PH_LEAD;
            lat_frac_in    = '0;
            lon_frac_in    = '0;
            sneg_in        = 1'b0;
            sseen_in       = 1'b0;
         end else if (char_count_ff < CW'(LINE_LIMIT)) begin
            char_count_in = char_count_ff + 1'b1;
            if (flags_ff[FL_CR]) begin
               char_count_in = char_count_ff + 1'b1;
            end else if (c == CHAR_CR) begin
               flags_in[FL_CR] = 1'b1;
            end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
               if (flags_ff[FL_STARTED]) begin
                  blank_run_in = blank_run_ff + 1'b1;
               end
            end else begin
               if (blank_run_ff != '0) begin
                  tsum = (CW + 1)'(trim_ff) + (CW + 1)'(blank_run_ff);
                  if (trim_ff <= 3'd1 && tsum >= (CW + 1)'(2)) begin
                     flags_in[FL_TALKER_G] = 1'b0;
                  end
                  if (trim_ff <= 3'd5 && tsum >= (CW + 1)'(4)) begin
                     kind_in = KIND_NONE;
                  end
                  trim_in = (tsum > (CW + 1)'(7)) ? 3'd7 : tsum[2:0];
                  if (!flags_ff[FL_STAR]) begin
                     i = fcc_ff;
                     fsum = (CW + 1)'(fcc_ff) + (CW + 1)'(blank_run_ff);
                     fcc_in = (fsum > (CW + 1)'(LINE_LIMIT)) ? CW'(LINE_LIMIT) : fsum[CW-1:0];
                     iend = fsum - 1'b1;
                     case (field_index_ff)
                        FIELD_STATUS: flags_in[FL_STATUS_A] = 1'b0;
                        FIELD_NS:     hem_in[0] = 1'b0;
                        FIELD_EW:     hem_in[1] = 1'b0;
                        FIELD_LAT, FIELD_LON: begin
                           dd = (field_index_ff == FIELD_LAT) ? 2'd2 : 2'd3;
                           if (i < CW'(dd) && dphase_ff != PH_LEAD) begin
                              dphase_in = PH_DONE;
                           end
                           if (iend >= (CW + 1)'(dd) && mphase_ff != PH_LEAD) begin
                              mphase_in = PH_DONE;
                           end
                        end
                        FIELD_SATS: begin
                           sseen_in = 1'b1;
                           if (sphase_ff != PH_LEAD) begin
                              sphase_in = PH_DONE;
                           end
                        end
                        default: sseen_in = sseen_ff;
                     endcase
                     if (field_index_ff == FIELD_LAT && fcc_in >= CW'(4)) begin
                        flags_in[FL_LAT_LEN] = 1'b1;
                     end
                     if (field_index_ff == FIELD_LON && fcc_in >= CW'(5)) begin
                        flags_in[FL_LON_LEN] = 1'b1;
                     end
                  end
                  blank_run_in = '0;
               end
               flags_in[FL_STARTED] = 1'b1;
               case (trim_in)
                  3'd0: if (c == CHAR_DOLLAR) flags_in[FL_DOLLAR] = 1'b1;
                  3'd1: if (c == CHAR_G) flags_in[FL_TALKER_G] = 1'b1;
                  3'd3: kind_in = (c == CHAR_R) ? KIND_RMC : ((c == CHAR_G) ? KIND_GGA : KIND_NONE);
                  3'd4: begin
                     if ((kind_in == KIND_RMC && c != CHAR_M) ||
                         (kind_in == KIND_GGA && c != CHAR_G)) begin
                        kind_in = KIND_NONE;
                     end
                  end
                  3'd5: begin
                     if ((kind_in == KIND_RMC && c != CHAR_C) ||
                         (kind_in == KIND_GGA && c != CHAR_A)) begin
                        kind_in = KIND_NONE;
                     end
                  end
                  default: kind_in = kind_in;
               endcase
               trim_in = (trim_in == 3'd7) ? 3'd7 : trim_in + 3'd1;
               if (!flags_in[FL_STAR]) begin
                  if (c == CHAR_STAR) begin
                     flags_in[FL_STAR] = 1'b1;
                  end else if (c == CHAR_COMMA) begin
                     if (field_index_in < FIELD_MAX) begin
                        field_index_in = field_index_in + 5'd1;
                     end
                     fcc_in    = '0;
                     dphase_in = PH_LEAD;
                     mphase_in = PH_LEAD;
                     sphase_in = PH_LEAD;
                  end else begin
                     i = fcc_in;
                     fcc_in = (fcc_in >= CW'(LINE_LIMIT)) ? CW'(LINE_LIMIT) : fcc_in + 1'b1;
                     case (field_index_in)
                        FIELD_STATUS: flags_in[FL_STATUS_A] = (i == '0) && (c == CHAR_A);
                        FIELD_NS:     hem_in[0] = (i == '0) && (c == CHAR_S);
                        FIELD_EW:     hem_in[1] = (i == '0) && (c == CHAR_W);
                        FIELD_LAT: begin
                           co = '{deg: 10'(lat_deg_in), mins: lat_min_in, frac: lat_frac_in,
                                  dphase: dphase_in, mphase: mphase_in};
                           co = coord_char(co, c, i, 2'd2);
                           lat_deg_in  = co.deg[6:0];
                           lat_min_in  = co.mins;
                           lat_frac_in = co.frac;
                           dphase_in   = co.dphase;
                           mphase_in   = co.mphase;
                        end
                        FIELD_LON: begin
                           co = '{deg: lon_deg_in, mins: lon_min_in, frac: lon_frac_in,
                                  dphase: dphase_in, mphase: mphase_in};
                           co = coord_char(co, c, i, 2'd3);
                           lon_deg_in  = co.deg;
                           lon_min_in  = co.mins;
                           lon_frac_in = co.frac;
                           dphase_in   = co.dphase;
                           mphase_in   = co.mphase;
                        end
                        FIELD_SATS: begin
                           sseen_in = 1'b1;
                           if (sphase_in == PH_LEAD && is_ws(c)) begin
                              sphase_in = PH_LEAD;
                           end else if (sphase_in == PH_LEAD &&
                                        (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                              sneg_in   = (c == CHAR_MINUS);
                              sphase_in = PH_INT;
                           end else if (sphase_in != PH_DONE) begin
                              if (is_digit(c)) begin
                                 sat_sum = 12'(sat_acc_in) * 12'd10 + 12'(c[3:0]);
                                 sat_acc_in = (sat_sum > 12'd255) ? 8'd255 : sat_sum[7:0];
                                 sphase_in = PH_INT;
                              end else begin
                                 sphase_in = PH_DONE;
                              end
                           end
                        end
                        default: sseen_in = sseen_in;
                     endcase
                  end
               end
               if (field_index_in == FIELD_LAT && fcc_in >= CW'(4)) begin
                  flags_in[FL_LAT_LEN] = 1'b1;
               end
               if (field_index_in == FIELD_LON && fcc_in >= CW'(5)) begin
                  flags_in[FL_LON_LEN] = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      logic       dollar;
      logic       head;
      logic [5:0] fields;
      logic       acc;
      dollar = flags_ff[FL_DOLLAR];
      head   = dollar && trim_ff >= 3'd6;
      fields = 6'(field_index_ff) + ((fcc_ff != '0) ? 6'd1 : 6'd0);
      acc    = cfg_g_ff ? (trim_ff > 3'd6 && dollar && flags_ff[FL_TALKER_G]) : 1'b1;
      st_in[1]          = '0;
      st_in[1].accepted = acc;
      st_in[1].rmc      = acc && head && kind_ff == KIND_RMC && fields >= 6'd7 &&
                          flags_ff[FL_STATUS_A] && flags_ff[FL_LAT_LEN] &&
                          flags_ff[FL_LON_LEN];
      st_in[1].gga      = acc && head && kind_ff == KIND_GGA && sseen_ff;
      st_in[1].sat      = (st_in[1].gga && !sneg_ff) ? sat_acc_ff : 8'd0;
      st_in[1].lat.deg  = 10'(lat_deg_ff);
      st_in[1].lat.mins = lat_min_ff;
      st_in[1].lat.frac = lat_frac_ff;
      st_in[1].lat.neg  = hem_ff[0];
      st_in[1].lon.deg  = lon_deg_ff;
      st_in[1].lon.mins = lon_min_ff;
      st_in[1].lon.frac = lon_frac_ff;
      st_in[1].lon.neg  = hem_ff[1];
      st_in[2] = st_ff[1];
      st_in[2].lat = pad_fn(st_ff[1].lat);
      st_in[2].lon = pad_fn(st_ff[1].lon);
      st_in[3] = st_ff[2];
      st_in[3].lat = mult_fn(st_ff[2].lat);
      st_in[3].lon = mult_fn(st_ff[2].lon);
      st_in[4] = st_ff[3];
      st_in[4].lat = pp_fn(st_ff[3].lat);
      st_in[4].lon = pp_fn(st_ff[3].lon);
      st_in[5] = st_ff[4];
      st_in[5].lat = sum_fn(st_ff[4].lat);
      st_in[5].lon = sum_fn(st_ff[4].lon);
      st_in[6] = st_ff[5];
      st_in[6].lat = mag_fn(st_ff[5].lat, LAT_CAP);
      st_in[6].lon = mag_fn(st_ff[5].lon, LON_CAP);
   end

   always_comb begin
      logic [30:0] lm;
      logic [34:0] om;
      lm = st_ff[NS].lat.mag[30:0];
      om = st_ff[NS].lon.mag[34:0];
      latitude_in  = '0;
      longitude_in = '0;
      if (st_ff[NS].rmc) begin
         latitude_in  = st_ff[NS].lat.neg ? lat_type'(~lm + 31'd1) : lat_type'(lm);
         longitude_in = st_ff[NS].lon.neg ? lon_type'(~om + 35'd1) : lon_type'(om);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_g_ff       <= 1'b0;
         char_count_ff  <= '0;
         field_index_ff <= '0;
         fcc_ff         <= '0;
         flags_ff       <= '0;
         kind_ff        <= KIND_NONE;
         lat_deg_ff     <= '0;
         lat_min_ff     <= '0;
         lon_deg_ff     <= '0;
         lon_min_ff     <= '0;
         hem_ff         <= '0;
         sat_acc_ff     <= '0;
         trim_ff        <= '0;
         blank_run_ff   <= '0;
         dphase_ff      <= PH_LEAD;
         mphase_ff      <= PH_LEAD;
         sphase_ff      <= PH_LEAD;
         lat_frac_ff    <= '0;
         lon_frac_ff    <= '0;
         sneg_ff        <= 1'b0;
         sseen_ff       <= 1'b0;
         v_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr.valid) begin
            cfg_g_ff <= csr.require_g_talker;
         end
         char_count_ff  <= char_count_in;
         field_index_ff <= field_index_in;
         fcc_ff         <= fcc_in;
         flags_ff       <= flags_in;
         kind_ff        <= kind_in;
         lat_deg_ff     <= lat_deg_in;
         lat_min_ff     <= lat_min_in;
         lon_deg_ff     <= lon_deg_in;
         lon_min_ff     <= lon_min_in;
         hem_ff         <= hem_in;
         sat_acc_ff     <= sat_acc_in;
         trim_ff        <= trim_in;
         blank_run_ff   <= blank_run_in;
         dphase_ff      <= dphase_in;
         mphase_ff      <= mphase_in;
         sphase_ff      <= sphase_in;
         lat_frac_ff    <= lat_frac_in;
         lon_frac_ff    <= lon_frac_in;
         sneg_ff        <= sneg_in;
         sseen_ff       <= sseen_in;
         if (rdy[1]) begin
            v_ff[1] <= byte_fire && (req.rx_byte == CHAR_LF);
         end
         for (int k = 2; k <= NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (rdy[NS+1]) begin
            rsp_valid_ff <= v_ff[NS];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NS; k++) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
      if (rdy[NS+1]) begin
         accepted_ff         <= st_ff[NS].accepted;
         position_valid_ff   <= st_ff[NS].rmc;
         satellites_valid_ff <= st_ff[NS].gga;
         satellites_ff       <= st_ff[NS].sat;
         latitude_ff         <= latitude_in;
         longitude_ff        <= longitude_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.line_accepted    = accepted_ff;
   assign rsp.position_valid   = position_valid_ff;
   assign rsp.latitude         = latitude_ff;
   assign rsp.longitude        = longitude_ff;
   assign rsp.satellites_valid = satellites_valid_ff;
   assign rsp.satellites       = satellites_ff;

endmodule

FILE: sv/nrgpp_checker.sv
`timescale 1ns / 1ps
`include "nmea_rmc_gga_position_parser_defines.svh"

module nrgpp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_line_accepted,
   input logic               rsp_position_valid,
   input logic signed [30:0] rsp_latitude,
   input logic signed [34:0] rsp_longitude,
   input logic               rsp_satellites_valid,
   input logic [7:0]         rsp_satellites
);

   `NRGPP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_latitude) && $stable(rsp_longitude), "Stalled result word changed")
   `NRGPP_ASSERT(a_reject_zero, clock, reset, rsp_valid && !rsp_line_accepted |-> !rsp_position_valid && !rsp_satellites_valid && rsp_latitude == 0 && rsp_longitude == 0 && rsp_satellites == 0, "Rejected line carries data")
   `NRGPP_ASSERT(a_kind_excl, clock, reset, rsp_valid |-> !(rsp_position_valid && rsp_satellites_valid), "Line reported as both RMC and GGA")
   `NRGPP_ASSERT(a_lat_range, clock, reset, rsp_valid && rsp_position_valid |-> rsp_latitude <= 31'sd1000000000 && rsp_latitude >= -31'sd1000000000, "Latitude beyond its limit")
   `NRGPP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "Result word valid after reset")

endmodule

bind nmea_rmc_gga_position_parser nrgpp_checker u_nrgpp_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .rsp_line_accepted    (rsp.line_accepted),
   .rsp_position_valid   (rsp.position_valid),
   .rsp_latitude         (rsp.latitude),
   .rsp_longitude        (rsp.longitude),
   .rsp_satellites_valid (rsp.satellites_valid),
   .rsp_satellites       (rsp.satellites)
);
